// ===== rtl/apmp_pkg.sv =====
// shared types and constants for the ascii pair multiply parser
`timescale 1ns / 1ps

package apmp_pkg;

  // parse phase within one line
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_DONE   = 2'd2,
    PH_BAD    = 2'd3
  } phase_e;

  // one finished line handed from the parser to the multiply side
  typedef struct packed {
    logic        format_ok;
    logic [31:0] first_value;
    logic [31:0] second_value;
  } line_rec_t;

  // characters of interest
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // threshold after reset
  localparam logic [31:0] LED_THRESHOLD_RESET = 32'd100;

  // line queue between parser and multiply side
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

endpackage

// ===== rtl/apmp_front.sv =====
// byte parser: accumulates the two numbers and closes lines
`timescale 1ns / 1ps

module apmp_front #(
  parameter int unsigned LINE_CHARS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output apmp_pkg::line_rec_t  q_data_o
);

  localparam int unsigned CNT_W = $clog2(LINE_CHARS + 1);

  apmp_pkg::phase_e phase_q, phase_d;
  logic [31:0]      first_q, first_d;
  logic [31:0]      second_q, second_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic        accept;
  logic        is_eol;
  logic        is_digit;
  logic        line_full;
  logic        line_end;
  logic [31:0] digit_ext;

  // byte classification
  assign accept    = in_valid_i && !in_stall_o;
  assign is_eol    = (rx_byte_i == apmp_pkg::CHAR_CR) || (rx_byte_i == apmp_pkg::CHAR_LF);
  assign is_digit  = (rx_byte_i >= apmp_pkg::CHAR_ZERO) && (rx_byte_i <= apmp_pkg::CHAR_NINE);
  assign digit_ext = {28'd0, rx_byte_i[3:0]};
  assign line_full = (count_q == CNT_W'(LINE_CHARS - 1));
  assign line_end  = is_eol || line_full;

  // hold off input while the line queue has no room
  assign in_stall_o = q_full_i;

  // parse step for a stored byte
  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    if (!is_eol) begin
      unique case (phase_q)
        apmp_pkg::PH_FIRST: begin
          if (is_digit) begin
            first_d = (first_q << 3) + (first_q << 1) + digit_ext;
          end else if (rx_byte_i == apmp_pkg::CHAR_SLASH) begin
            phase_d = apmp_pkg::PH_SECOND;
          end else begin
            phase_d = apmp_pkg::PH_BAD;
          end
        end
        apmp_pkg::PH_SECOND: begin
          if (is_digit) begin
            second_d = (second_q << 3) + (second_q << 1) + digit_ext;
          end else begin
            phase_d = apmp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    count_d = count_q + CNT_W'(1);
  end

  // line record from the state after this byte
  always_comb begin
    q_data_o.format_ok    = (phase_d == apmp_pkg::PH_SECOND) || (phase_d == apmp_pkg::PH_DONE);
    q_data_o.first_value  = first_d;
    q_data_o.second_value = q_data_o.format_ok ? second_d : 32'd0;
  end

  assign q_push_o = accept && line_end;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= apmp_pkg::PH_FIRST;
      first_q  <= '0;
      second_q <= '0;
      count_q  <= '0;
    end else if (accept) begin
      if (line_end) begin
        phase_q  <= apmp_pkg::PH_FIRST;
        first_q  <= '0;
        second_q <= '0;
        count_q  <= '0;
      end else begin
        phase_q  <= phase_d;
        first_q  <= first_d;
        second_q <= second_d;
        count_q  <= count_d;
      end
    end
  end

`ifndef SYNTHESIS
  // stored count never reaches the line length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CNT_W'(LINE_CHARS))
    else $error("stored count out of range");

  // a closed line restarts the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> (count_q == '0) && (phase_q == apmp_pkg::PH_FIRST) && (second_q == 32'd0))
    else $error("parser not restarted after line end");
`endif

endmodule

// ===== rtl/apmp_fifo.sv =====
// small queue of finished lines between parser and multiply side
`timescale 1ns / 1ps

module apmp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  apmp_pkg::line_rec_t  wr_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output apmp_pkg::line_rec_t  rd_data_o
);

  localparam int unsigned PW = apmp_pkg::FIFO_PTR_W;

  apmp_pkg::line_rec_t entries_q [apmp_pkg::FIFO_DEPTH];
  logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PW:0]         cnt_q;

  assign full_o    = (cnt_q == (PW + 1)'(apmp_pkg::FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = entries_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW + 1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // no push into a full queue, no pop from an empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("line queue overflow or underflow");
`endif

endmodule

// ===== rtl/apmp_back.sv =====
// multiply, threshold compare, led state and result register
`timescale 1ns / 1ps

module apmp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          threshold_i,
  input  logic                 q_empty_i,
  input  apmp_pkg::line_rec_t  q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 format_ok_o,
  output logic signed [31:0]   first_value_o,
  output logic signed [31:0]   second_value_o,
  output logic signed [31:0]   product_o,
  output logic                 led_on_o
);

  logic                s1_valid_q;
  apmp_pkg::line_rec_t s1_rec_q;
  logic [31:0]         s1_prod_q;

  logic                out_valid_q;
  apmp_pkg::line_rec_t out_rec_q;
  logic [31:0]         out_prod_q;
  logic                led_q, led_d;

  logic s2_en;
  logic s1_ready;

  // pipeline advance
  assign s2_en    = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_en;
  assign q_pop_o  = !q_empty_i && s1_ready;

  // led update for a valid line
  always_comb begin
    led_d = led_q;
    if (s1_valid_q && s1_rec_q.format_ok) begin
      led_d = $signed(s1_prod_q) > $signed(threshold_i);
    end
  end

  // multiply stage payload
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_rec_q  <= q_data_i;
      s1_prod_q <= q_data_i.first_value * q_data_i.second_value;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      out_rec_q  <= s1_rec_q;
      out_prod_q <= s1_prod_q;
    end
  end

  // valid bits and led state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      led_q       <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_pop_o;
      end
      if (s2_en) begin
        out_valid_q <= s1_valid_q;
        led_q       <= led_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign format_ok_o    = out_rec_q.format_ok;
  assign first_value_o  = out_rec_q.first_value;
  assign second_value_o = out_rec_q.second_value;
  assign product_o      = out_prod_q;
  assign led_on_o       = led_q;

`ifndef SYNTHESIS
  // an invalid line leaves the led alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_en && s1_valid_q && !s1_rec_q.format_ok) |=> $stable(led_q))
    else $error("led changed on invalid line");
`endif

endmodule

// ===== rtl/ascii_pair_multiply_parser_core.sv =====
// top level of the ascii pair multiply parser
`timescale 1ns / 1ps

// Takes one received byte per cycle and parses lines of the form decimal/decimal,
// ending at CR, LF or after LINE_CHARS stored bytes; each line end gives one result
// with the format flag, both numbers, their wrapped product and the led state.
// The parser accepts a byte every cycle while the queue has room; a finished line
// goes into a four-line queue, then through a multiply stage and an output
// register that holds its result. Input stalls only while that queue is
// full, which happens when the output side is held off.
// The threshold register may be written while no line is in flight.

module ascii_pair_multiply_parser_core #(
  parameter int unsigned LINE_CHARS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               format_ok_o,
  output logic signed [31:0] first_value_o,
  output logic signed [31:0] second_value_o,
  output logic signed [31:0] product_o,
  output logic               led_on_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0]         threshold_q;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  apmp_pkg::line_rec_t q_wr_data;
  apmp_pkg::line_rec_t q_rd_data;

  // threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= apmp_pkg::LED_THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      threshold_q <= cfg_data_i;
    end
  end

  // byte parser
  apmp_front #(
    .LINE_CHARS(LINE_CHARS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .rx_byte_i (rx_byte_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wr_data)
  );

  // line queue
  apmp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wr_data_i(q_wr_data),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .empty_o  (q_empty),
    .rd_data_o(q_rd_data)
  );

  // multiply and result side
  apmp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .threshold_i   (threshold_q),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rd_data),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .format_ok_o   (format_ok_o),
    .first_value_o (first_value_o),
    .second_value_o(second_value_o),
    .product_o     (product_o),
    .led_on_o      (led_on_o)
  );

`ifndef SYNTHESIS
  // a line closed while the queue is full would be lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && q_full |-> in_stall_o)
    else $error("byte accepted with full line queue");
`endif

endmodule
